[rtl/core/salc_pkg.sv]
// Shared types and constants for the set-associative LRU cache tag model.
// Used by salc_front, salc_back and set_assoc_lru_cache_tag_model.
// No dependencies.
package salc_pkg;

   // Command codes on req_command
   typedef enum logic [1:0] {
      OP_DLOAD  = 2'd0,
      OP_DSTORE = 2'd1,
      OP_ILOAD  = 2'd2,
      OP_FLUSH  = 2'd3
   } salc_op_type;

   // Outcome codes on rsp_outcome
   typedef enum logic [1:0] {
      OUT_HIT     = 2'd0,
      OUT_FILL    = 2'd1,
      OUT_REPLACE = 2'd2,
      OUT_NOALLOC = 2'd3
   } salc_outcome_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_SPLIT      = 3'd0,
      REG_DATA_SIZE  = 3'd1,
      REG_INST_SIZE  = 3'd2,
      REG_BLOCK      = 3'd3,
      REG_WAYS       = 3'd4,
      REG_WRITE_BACK = 3'd5,
      REG_WRITE_ALLOC = 3'd6
   } salc_reg_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS,
      ST_FLUSH,
      ST_MUL,
      ST_DONE
   } salc_state_type;

   localparam int TAG_W      = 32;
   localparam int WORDS_W    = 9;
   localparam int FETCH_W    = 7;
   localparam int COPY_W     = 20;
   localparam int QDEPTH     = 2;
   localparam logic [3:0] BLOCK_MIN = 4'd2;
   localparam logic [3:0] BLOCK_MAX = 4'd8;
   localparam logic [TAG_W-1:0] TAG_KEEP = 32'hFFFF_FFFF;
   localparam logic [FETCH_W-1:0] FETCH_SAT = 7'd127;
   localparam logic [COPY_W-1:0] COPY_SAT = 20'hF_FFFF;

   typedef struct packed {
      logic       split;
      logic [4:0] data_size;
      logic [4:0] inst_size;
      logic [3:0] block;
      logic [1:0] ways;
      logic       write_back;
      logic       write_alloc;
   } salc_cfg_type;

   // One classified command as it travels from front to back
   typedef struct packed {
      salc_op_type      op;
      logic             cache;
      logic [TAG_W-1:0] tag;
   } salc_item_type;

   function automatic logic [3:0] clamp_block(input logic [3:0] b);
      logic [3:0] r;
      r = b;
      if (b < BLOCK_MIN) r = BLOCK_MIN;
      if (b > BLOCK_MAX) r = BLOCK_MAX;
      return r;
   endfunction

endpackage

[rtl/core/salc_front.sv]
// Front end: accepts commands, splits the address into set and tag,
// and holds them in a short queue for the back end. Uses salc_pkg.
module salc_front
   import salc_pkg::*;
#(
   parameter int MAX_SETS_LOG2 = 10,
   parameter int ADDRESS_BITS  = 32,
   localparam int SW = (MAX_SETS_LOG2 > 0) ? MAX_SETS_LOG2 : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  salc_cfg_type        cfg,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_command,
   input  logic [31:0]         req_address,
   input  logic                clearing,
   output logic                q_valid,
   output salc_item_type       q_item,
   output logic [SW-1:0]       q_set,
   input  logic                q_pop
);

   localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CW = $clog2(QDEPTH + 1);
   localparam logic [31:0] ADDR_MASK =
      (ADDRESS_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << ADDRESS_BITS) - 32'd1);

   salc_item_type   item_ff [QDEPTH];
   logic [SW-1:0]   set_ff [QDEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   logic [31:0]        addr_m, set_mask, set_full;
   logic [3:0]         blk;
   logic [4:0]         size, sl_u;
   logic signed [6:0]  sl;
   salc_item_type      new_item;
   logic [SW-1:0]      new_set;
   logic               push;

   // Address split
   always_comb begin
      addr_m = req_address & ADDR_MASK;
      blk    = clamp_block(cfg.block);
      new_item.op    = salc_op_type'(req_command);
      new_item.cache = (req_command == OP_ILOAD) && cfg.split;
      size = new_item.cache ? cfg.inst_size : cfg.data_size;
      sl   = $signed({2'b00, size}) - $signed({3'b000, blk}) - $signed({5'b00000, cfg.ways});
      if (sl < 7'sd0) begin
         sl_u = 5'd0;
      end else if (sl > 7'(MAX_SETS_LOG2)) begin
         sl_u = 5'(MAX_SETS_LOG2);
      end else begin
         sl_u = sl[4:0];
      end
      set_mask = (32'd1 << sl_u) - 32'd1;
      set_full = (addr_m >> blk) & set_mask;
      new_set  = SW'(set_full);
      new_item.tag = (addr_m >> (5'(blk) + sl_u)) & TAG_KEEP;
   end

   // Queue control
   assign busy    = clearing || (count_ff == CW'(QDEPTH));
   assign push    = start && !busy;
   assign q_valid = (count_ff != '0);
   assign q_item  = item_ff[rd_ptr_ff];
   assign q_set   = set_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) count_in = count_ff + 1'b1;
      if (!push && q_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff] <= new_item;
         set_ff[wr_ptr_ff]  <= new_set;
      end
   end

endmodule

[rtl/core/salc_back.sv]
// Back end: tag and flag memories, LRU update, flush sweep and reset
// clearing pass. Uses salc_pkg; fed by salc_front.
module salc_back
   import salc_pkg::*;
#(
   parameter int MAX_SETS_LOG2 = 10,
   parameter int MAX_WAYS      = 8,
   parameter int WORD_BYTES    = 4,
   localparam int SW = (MAX_SETS_LOG2 > 0) ? MAX_SETS_LOG2 : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  salc_cfg_type        cfg,
   input  logic                q_valid,
   input  salc_item_type       q_item,
   input  logic [SW-1:0]       q_set,
   output logic                q_pop,
   output logic                clearing,
   output logic                rsp_valid,
   output logic                rsp_is_instruction_side,
   output logic [1:0]          rsp_outcome,
   output logic [FETCH_W-1:0]  rsp_fetched_words,
   output logic [COPY_W-1:0]   rsp_copied_back_words
);

   localparam int AW   = MAX_SETS_LOG2 + 1;
   localparam int ROWS = 1 << AW;
   localparam int SETS = 1 << MAX_SETS_LOG2;
   localparam int WW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int NW   = $clog2(MAX_WAYS + 1);
   localparam int CNTW = $clog2(SETS * MAX_WAYS + 1);
   localparam int PRW  = CNTW + WORDS_W;

   typedef struct packed {
      logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
      logic [MAX_WAYS-1:0][WW-1:0]    rank;
   } tag_row_type;

   typedef struct packed {
      logic [MAX_WAYS-1:0] valid;
      logic [MAX_WAYS-1:0] dirty;
   } flag_row_type;

   tag_row_type   tag_mem_ff [ROWS];
   flag_row_type  flag_mem_ff [ROWS];
   tag_row_type   tag_rd_ff;
   flag_row_type  flag_rd_ff;

   salc_state_type  state_ff, state_in;
   logic [AW-1:0]   ctr_ff, ctr_in, row_ff, row_in;
   logic [CNTW-1:0] acc_ff, acc_in;
   logic [PRW-1:0]  prod_ff, prod_in;
   salc_item_type   cur_ff, cur_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_inst_ff, rsp_inst_in;
   logic [1:0]             rsp_outcome_ff, rsp_outcome_in;
   logic [FETCH_W-1:0]     rsp_fetched_ff, rsp_fetched_in;
   logic [COPY_W-1:0]      rsp_copied_ff, rsp_copied_in;

   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic                tag_we, flag_we;
   logic [AW-1:0]       flag_wa;
   tag_row_type         tag_wd;
   flag_row_type        flag_wd;

   // Access datapath results
   logic [WORDS_W-1:0]  words;
   logic [NW-1:0]       nways;
   logic                acc_write;
   salc_outcome_type    acc_outcome;
   logic [FETCH_W-1:0]  acc_fetched;
   logic [COPY_W-1:0]   acc_copied;
   tag_row_type         new_tag_row;
   flag_row_type        new_flag_row;

   // Geometry from live configuration; words per block from a small table
   always_comb begin
      unique case (clamp_block(cfg.block))
         4'd2:    words = WORDS_W'((1 << 2) / WORD_BYTES);
         4'd3:    words = WORDS_W'((1 << 3) / WORD_BYTES);
         4'd4:    words = WORDS_W'((1 << 4) / WORD_BYTES);
         4'd5:    words = WORDS_W'((1 << 5) / WORD_BYTES);
         4'd6:    words = WORDS_W'((1 << 6) / WORD_BYTES);
         4'd7:    words = WORDS_W'((1 << 7) / WORD_BYTES);
         default: words = WORDS_W'((1 << 8) / WORD_BYTES);
      endcase
      if ((1 << cfg.ways) > MAX_WAYS) begin
         nways = NW'(MAX_WAYS);
      end else begin
         nways = NW'(1 << cfg.ways);
      end
   end

   // Lookup, victim choice and LRU update for one set
   always_comb begin : access_calc
      logic          en [MAX_WAYS];
      logic          hit_found, inv_found, store, wb;
      logic [WW-1:0] hit_way, inv_way, best, target;
      logic [WW:0]   old_rank;
      logic          victim_dirty;
      hit_found = 1'b0;
      inv_found = 1'b0;
      hit_way   = '0;
      inv_way   = '0;
      best      = '0;
      store     = (cur_ff.op == OP_DSTORE);
      wb        = cfg.write_back;
      for (int w = 0; w < MAX_WAYS; w++) begin
         en[w] = (NW'(w) < nways);
         if (en[w] && flag_rd_ff.valid[w] && (tag_rd_ff.tag[w] == cur_ff.tag) && !hit_found) begin
            hit_found = 1'b1;
            hit_way   = WW'(w);
         end
         if (en[w] && !flag_rd_ff.valid[w] && !inv_found) begin
            inv_found = 1'b1;
            inv_way   = WW'(w);
         end
      end
      for (int w = 1; w < MAX_WAYS; w++) begin
         if (en[w] && (tag_rd_ff.rank[w] > tag_rd_ff.rank[best])) best = WW'(w);
      end

      priority if (hit_found) begin
         acc_outcome = OUT_HIT;
         target      = hit_way;
         old_rank    = {1'b0, tag_rd_ff.rank[hit_way]};
      end else if (store && !cfg.write_alloc) begin
         acc_outcome = OUT_NOALLOC;
         target      = '0;
         old_rank    = '0;
      end else if (inv_found) begin
         acc_outcome = OUT_FILL;
         target      = inv_way;
         old_rank    = (WW+1)'(nways);
      end else begin
         acc_outcome = OUT_REPLACE;
         target      = best;
         old_rank    = {1'b0, tag_rd_ff.rank[best]};
      end
      victim_dirty = flag_rd_ff.dirty[target];

      // Touch: age younger valid ways, target becomes most recent
      new_tag_row  = tag_rd_ff;
      new_flag_row = flag_rd_ff;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (en[i] && (WW'(i) != target) && flag_rd_ff.valid[i] &&
             ({1'b0, tag_rd_ff.rank[i]} < old_rank)) begin
            new_tag_row.rank[i] = tag_rd_ff.rank[i] + 1'b1;
         end
      end
      new_tag_row.rank[target] = '0;
      if (acc_outcome == OUT_HIT) begin
         if (store && wb) new_flag_row.dirty[target] = 1'b1;
      end else begin
         new_tag_row.tag[target]    = cur_ff.tag;
         new_flag_row.valid[target] = 1'b1;
         new_flag_row.dirty[target] = store && wb;
      end

      acc_write = (acc_outcome != OUT_NOALLOC);
      unique case (acc_outcome)
         OUT_HIT: begin
            acc_fetched = '0;
            acc_copied  = (store && !wb) ? COPY_W'(1) : '0;
         end
         OUT_NOALLOC: begin
            acc_fetched = '0;
            acc_copied  = COPY_W'(1);
         end
         default: begin
            acc_fetched = (words > WORDS_W'(FETCH_SAT)) ? FETCH_SAT : FETCH_W'(words);
            acc_copied  = (((acc_outcome == OUT_REPLACE) && victim_dirty) ?
                           COPY_W'(words) : '0) + COPY_W'(store && !wb);
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (ctr_ff == AW'(ROWS - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (q_valid) state_in = (q_item.op == OP_FLUSH) ? ST_FLUSH : ST_ACCESS;
         end
         ST_ACCESS: state_in = ST_IDLE;
         ST_FLUSH:  if (ctr_ff == AW'(SETS - 1)) state_in = ST_MUL;
         ST_MUL:    state_in = ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath controls
   always_comb begin
      q_pop          = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = '0;
      tag_we         = 1'b0;
      tag_wd         = new_tag_row;
      flag_we        = 1'b0;
      flag_wa        = row_ff;
      flag_wd        = new_flag_row;
      ctr_in         = ctr_ff;
      row_in         = row_ff;
      acc_in         = acc_ff;
      prod_in        = prod_ff;
      cur_in         = cur_ff;
      rsp_valid_in   = 1'b0;
      rsp_inst_in    = rsp_inst_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_fetched_in = rsp_fetched_ff;
      rsp_copied_in  = rsp_copied_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            flag_we = 1'b1;
            flag_wa = ctr_ff;
            flag_wd = '0;
            ctr_in  = ctr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               rd_en  = 1'b1;
               cur_in = q_item;
               ctr_in = '0;
               acc_in = '0;
               row_in = (AW'(q_item.cache) << MAX_SETS_LOG2) | AW'(q_set);
               rd_addr = (q_item.op == OP_FLUSH) ? '0 : row_in;
            end
         end
         ST_ACCESS: begin
            tag_we         = acc_write;
            flag_we        = acc_write;
            rsp_valid_in   = 1'b1;
            rsp_inst_in    = (cur_ff.op == OP_ILOAD);
            rsp_outcome_in = acc_outcome;
            rsp_fetched_in = acc_fetched;
            rsp_copied_in  = acc_copied;
         end
         ST_FLUSH: begin
            acc_in  = acc_ff + CNTW'($countones(flag_rd_ff.valid & flag_rd_ff.dirty));
            ctr_in  = ctr_ff + 1'b1;
            rd_en   = 1'b1;
            rd_addr = ctr_ff + 1'b1;
         end
         ST_MUL: begin
            prod_in = PRW'(acc_ff) * PRW'(words);
         end
         ST_DONE: begin
            rsp_valid_in   = 1'b1;
            rsp_inst_in    = 1'b0;
            rsp_outcome_in = OUT_HIT;
            rsp_fetched_in = '0;
            rsp_copied_in  = (64'(prod_ff) > 64'(COPY_SAT)) ? COPY_SAT : COPY_W'(prod_ff);
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ctr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctr_ff       <= ctr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      row_ff         <= row_in;
      acc_ff         <= acc_in;
      prod_ff        <= prod_in;
      cur_ff         <= cur_in;
      rsp_inst_ff    <= rsp_inst_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_fetched_ff <= rsp_fetched_in;
      rsp_copied_ff  <= rsp_copied_in;
   end

   // Tag and flag memories, registered read
   always_ff @(posedge clock) begin
      if (tag_we) tag_mem_ff[row_ff] <= tag_wd;
      if (flag_we) flag_mem_ff[flag_wa] <= flag_wd;
      if (rd_en) begin
         tag_rd_ff  <= tag_mem_ff[rd_addr];
         flag_rd_ff <= flag_mem_ff[rd_addr];
      end
   end

   assign clearing                = (state_ff == ST_CLEAR);
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_is_instruction_side = rsp_inst_ff;
   assign rsp_outcome             = rsp_outcome_ff;
   assign rsp_fetched_words       = rsp_fetched_ff;
   assign rsp_copied_back_words   = rsp_copied_ff;

endmodule

[rtl/core/set_assoc_lru_cache_tag_model.sv]
// Top level of the set-associative LRU cache tag model: configuration
// registers, front end and back end. Uses salc_pkg, salc_front, salc_back.
//
// Usage: drive req_command and req_address with start high; the command is
// taken at a clock edge where busy is low. Each command yields one beat on
// the rsp_ ports, marked by rsp_valid for exactly one cycle; the receiver
// cannot stall, so beats are never held back.
// A load or store passes the queue, the tag/flag memory read, and the
// lookup and write-back of the set before its beat is registered on the
// rsp_ ports; the back end finishes the single read-modify-write of one
// set row in the memories before it takes the next command. A queue of two
// commands lets the front take new commands while the back works.
// Flush reads every data-side set row, one per cycle, then scales the
// count of dirty ways by the words per block before its beat; busy rises
// once the queue fills behind it.
// Reset: the registers take their reset values and a clearing pass over
// all 2^(MAX_SETS_LOG2+1) set rows zeroes valid and dirty marks, busy high
// throughout. csr_ writes are taken at any edge with csr_write_en high.
module set_assoc_lru_cache_tag_model
   import salc_pkg::*;
#(
   parameter int MAX_SETS_LOG2 = 10,
   parameter int MAX_WAYS      = 8,
   parameter int ADDRESS_BITS  = 32,
   parameter int WORD_BYTES    = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_command,
   input  logic [31:0]  req_address,
   output logic         rsp_valid,
   output logic         rsp_is_instruction_side,
   output logic [1:0]   rsp_outcome,
   output logic [6:0]   rsp_fetched_words,
   output logic [19:0]  rsp_copied_back_words,
   input  logic         csr_write_en,
   input  logic [2:0]   csr_index,
   input  logic [4:0]   csr_write_data
);

   localparam int SW = (MAX_SETS_LOG2 > 0) ? MAX_SETS_LOG2 : 1;

   salc_cfg_type   cfg_ff, cfg_in;
   logic           q_valid, q_pop, clearing;
   salc_item_type  q_item;
   logic [SW-1:0]  q_set;

   // Configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (salc_reg_type'(csr_index))
            REG_SPLIT:       cfg_in.split       = csr_write_data[0];
            REG_DATA_SIZE:   cfg_in.data_size   = csr_write_data;
            REG_INST_SIZE:   cfg_in.inst_size   = csr_write_data;
            REG_BLOCK:       cfg_in.block       = csr_write_data[3:0];
            REG_WAYS:        cfg_in.ways        = csr_write_data[1:0];
            REG_WRITE_BACK:  cfg_in.write_back  = csr_write_data[0];
            REG_WRITE_ALLOC: cfg_in.write_alloc = csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.split       <= 1'b0;
         cfg_ff.data_size   <= 5'd13;
         cfg_ff.inst_size   <= 5'd13;
         cfg_ff.block       <= 4'd4;
         cfg_ff.ways        <= 2'd0;
         cfg_ff.write_back  <= 1'b1;
         cfg_ff.write_alloc <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   salc_front #(
      .MAX_SETS_LOG2 (MAX_SETS_LOG2),
      .ADDRESS_BITS  (ADDRESS_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .start       (start),
      .busy        (busy),
      .req_command (req_command),
      .req_address (req_address),
      .clearing    (clearing),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_set       (q_set),
      .q_pop       (q_pop)
   );

   salc_back #(
      .MAX_SETS_LOG2 (MAX_SETS_LOG2),
      .MAX_WAYS      (MAX_WAYS),
      .WORD_BYTES    (WORD_BYTES)
   ) u_back (
      .clock                   (clock),
      .reset                   (reset),
      .cfg                     (cfg_ff),
      .q_valid                 (q_valid),
      .q_item                  (q_item),
      .q_set                   (q_set),
      .q_pop                   (q_pop),
      .clearing                (clearing),
      .rsp_valid               (rsp_valid),
      .rsp_is_instruction_side (rsp_is_instruction_side),
      .rsp_outcome             (rsp_outcome),
      .rsp_fetched_words       (rsp_fetched_words),
      .rsp_copied_back_words   (rsp_copied_back_words)
   );

endmodule

[verif/tb_top.sv]
// Self-checking testbench for set_assoc_lru_cache_tag_model.
// Holds a scoreboard class that predicts every response beat from its own
// tag, valid, dirty and LRU copy. Depends on salc_pkg and the RTL top level.
module tb_top;
   import salc_pkg::*;

   localparam int SETS_LOG2_MAX = 10;
   localparam int WAYS_MAX      = 8;
   localparam int LINES_HALF    = (1 << SETS_LOG2_MAX) * WAYS_MAX;
   localparam int LINES_ALL     = 2 * LINES_HALF;

   // One predicted response beat
   typedef struct {
      logic             inst_side;
      salc_outcome_type outcome;
      logic [6:0]       fetched;
      logic [19:0]      copied;
   } cache_rsp_type;

   class cache_scoreboard;
      salc_cfg_type    cfg;
      logic [31:0]     tag_mem[LINES_ALL];
      bit              valid_mem[LINES_ALL];
      bit              dirty_mem[LINES_ALL];
      int              rank_mem[LINES_ALL];
      cache_rsp_type   rsp_q[$];
      int              errors;
      int              hits;
      int              misses;
      int              flushes;
      int              beats;

      function new();
         cfg = '{split: 1'b0, data_size: 5'd13, inst_size: 5'd13, block: 4'd4,
                 ways: 2'd0, write_back: 1'b1, write_alloc: 1'b1};
         foreach (valid_mem[i]) begin
            valid_mem[i] = 0;
            dirty_mem[i] = 0;
            rank_mem[i]  = 0;
            tag_mem[i]   = '0;
         end
         errors = 0;
         hits = 0;
         misses = 0;
         flushes = 0;
         beats = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [4:0] data);
         case (idx)
            REG_SPLIT:       cfg.split       = data[0];
            REG_DATA_SIZE:   cfg.data_size   = data;
            REG_INST_SIZE:   cfg.inst_size   = data;
            REG_BLOCK:       cfg.block       = data[3:0];
            REG_WAYS:        cfg.ways        = data[1:0];
            REG_WRITE_BACK:  cfg.write_back  = data[0];
            REG_WRITE_ALLOC: cfg.write_alloc = data[0];
            default: ;
         endcase
      endfunction

      // Promote way w to most recent; younger valid ways age by one
      function void promote(int base, int nways, int w, int old_rank);
         for (int i = 0; i < nways; i++)
            if (i != w && valid_mem[base+i] && rank_mem[base+i] < old_rank)
               rank_mem[base+i]++;
         rank_mem[base+w] = 0;
      endfunction

      // Predict the beat for one accepted command
      function void note_command(logic [1:0] cmd, logic [31:0] addr);
         cache_rsp_type e;
         int blk, words, cache, size, wl, nways, sl, set, base, hit_way;
         int target, old_rank, best, n;
         longint copied, fetched;
         logic [31:0] tag;
         bit store, wb, wa;
         blk = cfg.block < 2 ? 2 : (cfg.block > 8 ? 8 : int'(cfg.block));
         words = (1 << blk) / 4;
         copied = 0;
         fetched = 0;
         e.outcome = OUT_HIT;
         if (cmd == OP_FLUSH) begin
            n = 0;
            for (int i = 0; i < LINES_HALF; i++)
               if (valid_mem[i] && dirty_mem[i]) n++;
            copied = longint'(n) * words;
            flushes++;
         end else begin
            cache = (cmd == OP_ILOAD && cfg.split) ? 1 : 0;
            size = cache ? int'(cfg.inst_size) : int'(cfg.data_size);
            wl = cfg.ways;
            nways = 1 << wl;
            sl = size - blk - wl;
            if (sl < 0) sl = 0;
            if (sl > SETS_LOG2_MAX) sl = SETS_LOG2_MAX;
            set = int'((addr >> blk) & ((32'd1 << sl) - 1));
            base = cache * LINES_HALF + set * WAYS_MAX;
            tag = addr >> (blk + sl);
            store = (cmd == OP_DSTORE);
            wb = cfg.write_back;
            wa = cfg.write_alloc;
            hit_way = -1;
            for (int w = 0; w < nways; w++)
               if (hit_way < 0 && valid_mem[base+w] && tag_mem[base+w] == tag)
                  hit_way = w;
            if (hit_way >= 0) begin
               promote(base, nways, hit_way, rank_mem[base+hit_way]);
               if (store) begin
                  if (wb) dirty_mem[base+hit_way] = 1;
                  else copied = 1;
               end
               hits++;
            end else if (store && !wa) begin
               e.outcome = OUT_NOALLOC;
               copied = 1;
               misses++;
            end else begin
               target = -1;
               for (int w = 0; w < nways; w++)
                  if (target < 0 && !valid_mem[base+w]) target = w;
               if (target >= 0) begin
                  e.outcome = OUT_FILL;
                  old_rank = nways;
               end else begin
                  best = 0;
                  for (int w = 1; w < nways; w++)
                     if (rank_mem[base+w] > rank_mem[base+best]) best = w;
                  target = best;
                  e.outcome = OUT_REPLACE;
                  old_rank = rank_mem[base+target];
                  if (dirty_mem[base+target]) copied = words;
               end
               tag_mem[base+target] = tag;
               valid_mem[base+target] = 1;
               dirty_mem[base+target] = store && wb;
               promote(base, nways, target, old_rank);
               fetched = words;
               if (store && !wb) copied += 1;
               misses++;
            end
         end
         if (fetched > 127) fetched = 127;
         if (copied > 20'hF_FFFF) copied = 20'hF_FFFF;
         e.inst_side = (cmd == OP_ILOAD);
         e.fetched = fetched[6:0];
         e.copied = copied[19:0];
         rsp_q.push_back(e);
      endfunction

      function void check_beat(logic inst_side, logic [1:0] outcome,
                               logic [6:0] fetched, logic [19:0] copied);
         cache_rsp_type e;
         beats++;
         if (rsp_q.size() == 0) begin
            $display("%0t: response beat with nothing expected", $time);
            errors++;
         end else begin
            e = rsp_q.pop_front();
            if (inst_side !== e.inst_side) begin
               $display("%0t: is_instruction_side exp %0d got %0d", $time,
                        e.inst_side, inst_side);
               errors++;
            end
            if (outcome !== e.outcome) begin
               $display("%0t: outcome exp %0d got %0d", $time, e.outcome, outcome);
               errors++;
            end
            if (fetched !== e.fetched) begin
               $display("%0t: fetched_words exp %0d got %0d", $time, e.fetched,
                        fetched);
               errors++;
            end
            if (copied !== e.copied) begin
               $display("%0t: copied_back_words exp %0d got %0d", $time,
                        e.copied, copied);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_command;
   logic [31:0] req_address;
   logic        rsp_valid;
   logic        rsp_is_instruction_side;
   logic [1:0]  rsp_outcome;
   logic [6:0]  rsp_fetched_words;
   logic [19:0] rsp_copied_back_words;
   logic        csr_write_en;
   logic [2:0]  csr_index;
   logic [4:0]  csr_write_data;

   cache_scoreboard sb;
   int accepted;
   int idle_pct;
   logic [31:0] addr_pool[16];

   set_assoc_lru_cache_tag_model DUT (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Monitor: command beats, csr writes and response beats at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_en) sb.write_reg(csr_index, csr_write_data);
         if (start && !busy) begin
            sb.note_command(req_command, req_address);
            accepted++;
         end
         if (rsp_valid)
            sb.check_beat(rsp_is_instruction_side, rsp_outcome,
                          rsp_fetched_words, rsp_copied_back_words);
      end
   end

   // Send one command beat, with random idle cycles ahead of it
   task automatic send_cmd(salc_op_type cmd, logic [31:0] addr);
      int seen;
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_address <= addr;
      seen = accepted;
      do @(negedge clock); while (accepted == seen);
   endtask

   // Hold off until every predicted beat has arrived, then let the pipe settle
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (sb.rsp_q.size() > 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_cfg(salc_cfg_type c);
      salc_reg_type idx;
      logic [4:0] val[7];
      val = '{{4'd0, c.split}, c.data_size, c.inst_size, {1'b0, c.block},
              {3'd0, c.ways}, {4'd0, c.write_back}, {4'd0, c.write_alloc}};
      for (int i = 0; i < 7; i++) begin
         idx = salc_reg_type'(i);
         csr_write_en <= 1'b1;
         csr_index <= idx;
         csr_write_data <= val[i];
         @(negedge clock);
      end
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly reuse of a small address pool so hits and replacements occur
   function automatic logic [31:0] pick_addr();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return addr_pool[$urandom_range(0, 15)];
      if (r < 80) return addr_pool[$urandom_range(0, 15)] ^ ($urandom_range(0, 63) << 
                         $urandom_range(2, 20));
      return $urandom;
   endfunction

   task automatic random_phase(int n);
      int r;
      salc_op_type cmd;
      for (int i = 0; i < 16; i++) addr_pool[i] = $urandom & 32'h0003_FFFF;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 199);
         if (r < 3) cmd = OP_FLUSH;
         else if (r < 80) cmd = OP_DLOAD;
         else if (r < 140) cmd = OP_DSTORE;
         else cmd = OP_ILOAD;
         if ($urandom_range(0, 49) == 0) addr_pool[$urandom_range(0, 15)] = $urandom;
         send_cmd(cmd, pick_addr());
         if (i == n / 2 && $urandom_range(0, 1)) drain();
      end
   endtask

   initial begin
      salc_cfg_type c;
      salc_cfg_type extremes[4];
      sb = new();
      accepted = 0;
      idle_pct = 37;
      reset = 1'b1;
      start = 1'b0;
      req_command = OP_DLOAD;
      req_address = '0;
      csr_write_en = 1'b0;
      csr_index = REG_SPLIT;
      csr_write_data = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed beats under the reset settings: fill, hit, replace, flush
      send_cmd(OP_DLOAD, 32'h0000_0000);
      send_cmd(OP_DLOAD, 32'h0000_0004);
      send_cmd(OP_DSTORE, 32'h0000_0008);
      send_cmd(OP_DSTORE, 32'hFFFF_FFFF);
      send_cmd(OP_DLOAD, 32'h0000_2000);
      send_cmd(OP_DLOAD, 32'h0000_0000);
      send_cmd(OP_ILOAD, 32'hFFFF_FFF0);
      send_cmd(OP_FLUSH, 32'h1234_5678);
      drain();
      // Split, write-through, no-allocate, four ways, smallest block
      write_cfg('{split: 1'b1, data_size: 5'd6, inst_size: 5'd21, block: 4'd2,
                  ways: 2'd2, write_back: 1'b0, write_alloc: 1'b0});
      send_cmd(OP_DSTORE, 32'h0000_0010);
      send_cmd(OP_DLOAD, 32'h0000_0010);
      send_cmd(OP_DSTORE, 32'h0000_0010);
      for (int i = 0; i < 5; i++) send_cmd(OP_DLOAD, 32'h0000_0100 * i);
      send_cmd(OP_ILOAD, 32'h0000_0010);
      send_cmd(OP_ILOAD, 32'hFFFF_FFFF);
      send_cmd(OP_FLUSH, 32'h0);
      drain();
      // Dirty replacement with the largest block, then a flush
      write_cfg('{split: 1'b0, data_size: 5'd8, inst_size: 5'd4, block: 4'd8,
                  ways: 2'd0, write_back: 1'b1, write_alloc: 1'b1});
      send_cmd(OP_DSTORE, 32'h0000_0000);
      send_cmd(OP_FLUSH, 32'h0);
      send_cmd(OP_DLOAD, 32'h8000_0000);
      send_cmd(OP_FLUSH, 32'hFFFF_FFFF);
      drain();

      extremes[0] = '{1'b1, 5'd4, 5'd21, 4'd2, 2'd3, 1'b0, 1'b0};
      extremes[1] = '{1'b0, 5'd21, 5'd4, 4'd8, 2'd0, 1'b1, 1'b1};
      extremes[2] = '{1'b1, 5'd31, 5'd0, 4'd15, 2'd3, 1'b1, 1'b0};
      extremes[3] = '{1'b0, 5'd0, 5'd31, 4'd0, 2'd1, 1'b0, 1'b1};
      for (int p = 0; p < 12; p++) begin
         idle_pct = p < 4 ? 37 : (p < 8 ? 56 : 0);
         if (p < 4) c = extremes[p];
         else if (p % 2 == 0)
            c = '{1'($urandom_range(0, 1)), 5'($urandom_range(6, 16)),
                  5'($urandom_range(6, 16)), 4'($urandom_range(2, 6)),
                  2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1))};
         else
            c = salc_cfg_type'($urandom);
         write_cfg(c);
         random_phase(150);
         drain();
      end

      $display("covered %0d commands: %0d hits, %0d misses, %0d flushes",
               accepted, sb.hits, sb.misses, sb.flushes);
      $display("15 register settings incl. size, block and way extremes, %0d beats",
               sb.beats);
      if (sb.errors == 0 && sb.rsp_q.size() == 0)
         $display("set_assoc_lru_cache_tag_model regression: pass");
      else
         $display("set_assoc_lru_cache_tag_model regression: fail");
      $finish;
   end

   // Watchdog
   initial begin
      #40_000_000;
      $display("set_assoc_lru_cache_tag_model regression: fail");
      $finish;
   end
endmodule

[filelist.f]
rtl/core/salc_pkg.sv
rtl/core/salc_front.sv
rtl/core/salc_back.sv
rtl/core/set_assoc_lru_cache_tag_model.sv
verif/tb_top.sv
